// ===== src/bis_pkg.sv =====
// Shared constants and types for the bilinear image scaler.
`timescale 1ns / 1ps
package bis_pkg;
   localparam int MAX_ROWS  = 512;
   localparam int MAX_COLS  = 512;
   localparam int FRAC_BITS = 8;

   localparam int COORD_W = 12;
   localparam int SCALE_W = 12;
   localparam int DIM_W   = 10;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam int PROD_W  = COORD_W + SCALE_W;
   localparam int POS_W   = PROD_W - FRAC_BITS;
   localparam int WT1_W   = FRAC_BITS + 1;
   localparam int WT_W    = 2 * FRAC_BITS + 2;
   localparam int TERM_W  = WT_W + CHAN_W;
   localparam int SUM_W   = TERM_W - 2 * FRAC_BITS + 2;

   // Four banks split by row and column parity.
   localparam int RIDX_W  = $clog2(MAX_ROWS) - 1;
   localparam int CIDX_W  = $clog2(MAX_COLS) - 1;
   localparam int BADDR_W = RIDX_W + CIDX_W;
   localparam int BDEPTH  = (MAX_ROWS / 2) * (MAX_COLS / 2);

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd2;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   localparam logic [DIM_W-1:0] ROWS_RESET  = DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0] COLS_RESET  = DIM_W'(MAX_COLS);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << FRAC_BITS);

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pix;
   } s1_type;

   typedef struct packed {
      logic               op;
      logic [PROD_W-1:0]  prow;
      logic [PROD_W-1:0]  pcol;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pix;
   } s2_type;

   typedef struct packed {
      logic                 op;
      logic                 rpar;
      logic                 cpar;
      logic [3:0]           in_img;
      logic [FRAC_BITS-1:0] u;
      logic [FRAC_BITS-1:0] v;
   } s3_type;

   typedef struct packed {
      logic                  op;
      logic [3:0][WT_W-1:0]  wt;
      logic [3:0][PIX_W-1:0] pix;
   } s4_type;
endpackage

// ===== src/bis_bank_ram.sv =====
// One pixel bank: synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
module bis_bank_ram #(
   parameter int DEPTH  = 65536,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== src/bilinear_image_scaler.sv =====
// Bilinear image scaler: banked source store and five-stage blend pipeline.
// A request word passes s1_ff, s2_ff, s3_ff, s4_ff and out_ff in turn before it shows on rsp_.
// Throughput: one word per cycle; the four neighbors come from four parity banks
// read in the same cycle, and the pipeline stalls only when rsp_ready is low.
// Reset clears the pipeline valid bits and loads the registers with 512, 512, 1.0.
// The pixel store is not cleared; only written pixels may be sampled.
`timescale 1ns / 1ps
module bilinear_image_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [bis_pkg::COORD_W-1:0]      req_row,
   input  logic [bis_pkg::COORD_W-1:0]      req_col,
   input  logic [bis_pkg::CHAN_W-1:0]       req_blue_in,
   input  logic [bis_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [bis_pkg::CHAN_W-1:0]       req_red_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_blue_out,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_red_out,
   input  logic                             csr_we,
   input  logic [bis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bis_pkg::CSR_W-1:0]        csr_wdata
);
   import bis_pkg::*;

   logic [DIM_W-1:0]   rows_ff, cols_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [DIM_W-1:0]   eff_rows, eff_cols;

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   logic [PIX_W-1:0] out_in, out_ff;

   logic [3:0]              bank_we;
   logic [BADDR_W-1:0]      wr_addr;
   logic [3:0][BADDR_W-1:0] rd_addr;
   logic [3:0][PIX_W-1:0]   rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_wdata[DIM_W-1:0];
            CSR_COLS:  cols_ff  <= csr_wdata[DIM_W-1:0];
            CSR_SCALE: scale_ff <= csr_wdata[SCALE_W-1:0];
            default:   ;
         endcase
      end
   end

   assign eff_rows = (rows_ff > ROWS_RESET) ? ROWS_RESET : rows_ff;
   assign eff_cols = (cols_ff > COLS_RESET) ? COLS_RESET : cols_ff;

   assign advance   = !v5_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1: capture the word
   always_comb begin
      s1_in.op  = req_op;
      s1_in.row = req_row;
      s1_in.col = req_col;
      s1_in.pix = {req_red_in, req_green_in, req_blue_in};
   end

   // stage 2: scale coordinates
   always_comb begin
      s2_in.op   = s1_ff.op;
      s2_in.prow = PROD_W'(s1_ff.row) * PROD_W'(scale_ff);
      s2_in.pcol = PROD_W'(s1_ff.col) * PROD_W'(scale_ff);
      s2_in.row  = s1_ff.row;
      s2_in.col  = s1_ff.col;
      s2_in.pix  = s1_ff.pix;
   end

   // stage 3: bank access; writes and reads share this stage so order holds
   logic [POS_W-1:0] r0, c0;
   logic [POS_W:0]   r1, c1;
   logic             r0_in, r1_in, c0_in, c1_in;
   logic             wr_ok;

   always_comb begin
      r0 = s2_ff.prow[PROD_W-1:FRAC_BITS];
      c0 = s2_ff.pcol[PROD_W-1:FRAC_BITS];
      r1 = {1'b0, r0} + 1'b1;
      c1 = {1'b0, c0} + 1'b1;
      r0_in = {1'b0, r0} < (POS_W+1)'(eff_rows);
      r1_in = r1 < (POS_W+1)'(eff_rows);
      c0_in = {1'b0, c0} < (POS_W+1)'(eff_cols);
      c1_in = c1 < (POS_W+1)'(eff_cols);

      s3_in.op     = s2_ff.op;
      s3_in.rpar   = r0[0];
      s3_in.cpar   = c0[0];
      s3_in.in_img = {r1_in & c1_in, r1_in & c0_in, r0_in & c1_in, r0_in & c0_in};
      s3_in.u      = s2_ff.prow[FRAC_BITS-1:0];
      s3_in.v      = s2_ff.pcol[FRAC_BITS-1:0];

      for (int b = 0; b < 4; b++) begin
         // bank b holds rows of parity b[1] and columns of parity b[0]
         rd_addr[b] = {((r0[0] == b[1]) ? r0[RIDX_W:1] : r1[RIDX_W:1]),
                       ((c0[0] == b[0]) ? c0[CIDX_W:1] : c1[CIDX_W:1])};
      end

      wr_ok = v2_ff && advance && (s2_ff.op == OP_WRITE)
              && (s2_ff.row < COORD_W'(eff_rows)) && (s2_ff.col < COORD_W'(eff_cols));
      wr_addr = {s2_ff.row[RIDX_W:1], s2_ff.col[CIDX_W:1]};
      for (int b = 0; b < 4; b++) begin
         bank_we[b] = wr_ok && (s2_ff.row[0] == b[1]) && (s2_ff.col[0] == b[0]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      bis_bank_ram #(.DEPTH(BDEPTH), .WIDTH(PIX_W)) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .wr_addr (wr_addr),
         .wr_data (s2_ff.pix),
         .rd_en   (advance),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // stage 4: route banks to neighbors, form weights
   logic [WT1_W-1:0] um, vm, uu, vv;
   always_comb begin
      uu = WT1_W'(s3_ff.u);
      vv = WT1_W'(s3_ff.v);
      um = WT1_W'(1 << FRAC_BITS) - uu;
      vm = WT1_W'(1 << FRAC_BITS) - vv;
      s4_in.op     = s3_ff.op;
      s4_in.wt[0]  = WT_W'(um) * WT_W'(vm);
      s4_in.wt[1]  = WT_W'(um) * WT_W'(vv);
      s4_in.wt[2]  = WT_W'(uu) * WT_W'(vm);
      s4_in.wt[3]  = WT_W'(uu) * WT_W'(vv);
      for (int k = 0; k < 4; k++) begin
         s4_in.pix[k] = s3_ff.in_img[k]
            ? rd_data[{s3_ff.rpar ^ k[1], s3_ff.cpar ^ k[0]}] : '0;
      end
   end

   // stage 5: weighted sum per channel, truncate each term, saturate
   always_comb begin
      logic [TERM_W-1:0] term;
      logic [SUM_W-1:0]  acc;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            term = TERM_W'(s4_ff.wt[k]) * TERM_W'(s4_ff.pix[k][ch*CHAN_W +: CHAN_W]);
            acc  = acc + SUM_W'(term >> (2 * FRAC_BITS));
         end
         out_in[ch*CHAN_W +: CHAN_W] = (acc > SUM_W'(255)) ? 8'hFF : acc[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff && (s4_ff.op == OP_REQUEST);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_blue_out  = out_ff[CHAN_W-1:0];
   assign rsp_green_out = out_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_red_out   = out_ff[3*CHAN_W-1:2*CHAN_W];
endmodule

// ===== sim/tb_bilinear_image_scaler.sv =====
// Self-checking testbench for the bilinear image scaler.
`timescale 1ns / 1ps
module tb_bilinear_image_scaler;
   import bis_pkg::*;

   // index past the register list; writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic               op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  red;
   } pixel_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = OP_WRITE;
   logic [COORD_W-1:0] req_row = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_blue_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_red_out;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   bilinear_image_scaler i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies as the block sees them
   int unsigned rows_cfg = MAX_ROWS;
   int unsigned cols_cfg = MAX_COLS;
   int unsigned scale_cfg = 1 << FRAC_BITS;

   logic [PIX_W-1:0] image_store [int];  // pixels written so far, by row*MAX_COLS+col
   bit planned_pixels [int];             // pixels that queued writes will hold
   pixel_word_type pending_words [$];
   logic [PIX_W-1:0] expected_pixels [$];
   int mismatches = 0;

   function automatic int unsigned eff_rows();
      return (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
   endfunction

   function automatic int unsigned eff_cols();
      return (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
   endfunction

   function automatic bit in_image(longint unsigned r, longint unsigned c);
      return (r < eff_rows()) && (c < eff_cols());
   endfunction

   function automatic logic [PIX_W-1:0] neighbor(longint unsigned r, longint unsigned c);
      int key;
      if (!in_image(r, c)) return '0;
      key = int'(r) * MAX_COLS + int'(c);
      return image_store.exists(key) ? image_store[key] : '0;
   endfunction

   function automatic logic [PIX_W-1:0] blend_pixel(int unsigned row, int unsigned col);
      longint unsigned one, pr, pc, u, v, sum, chan;
      longint unsigned r0, c0;
      longint unsigned wt [4];
      logic [PIX_W-1:0] px [4];
      logic [PIX_W-1:0] res;
      one = 64'd1 << FRAC_BITS;
      pr = longint'(row) * scale_cfg;
      pc = longint'(col) * scale_cfg;
      r0 = pr >> FRAC_BITS;
      c0 = pc >> FRAC_BITS;
      u = pr & (one - 1);
      v = pc & (one - 1);
      wt[0] = (one - u) * (one - v);
      wt[1] = (one - u) * v;
      wt[2] = u * (one - v);
      wt[3] = u * v;
      px[0] = neighbor(r0, c0);
      px[1] = neighbor(r0, c0 + 1);
      px[2] = neighbor(r0 + 1, c0);
      px[3] = neighbor(r0 + 1, c0 + 1);
      for (int ch = 0; ch < 3; ch++) begin
         sum = 0;
         for (int k = 0; k < 4; k++) begin
            chan = (px[k] >> (CHAN_W * ch)) & 8'hFF;
            sum += (wt[k] * chan) >> (2 * FRAC_BITS);
         end
         res[CHAN_W*ch +: CHAN_W] = (sum > 255) ? 8'hFF : sum[7:0];
      end
      return res;
   endfunction

   // Stimulus builders
   task automatic add_write(int unsigned row, int unsigned col,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r);
      pixel_word_type w;
      w.op = OP_WRITE;
      w.row = row[COORD_W-1:0];
      w.col = col[COORD_W-1:0];
      w.blue = b;
      w.green = g;
      w.red = r;
      if (in_image(row, col)) planned_pixels[row * MAX_COLS + col] = 1'b1;
      pending_words.push_back(w);
   endtask

   // A request goes out only after all its in-image neighbors have been written.
   task automatic add_request(int unsigned row, int unsigned col);
      pixel_word_type w;
      longint unsigned r0, c0, rr, cc;
      r0 = (longint'(row) * scale_cfg) >> FRAC_BITS;
      c0 = (longint'(col) * scale_cfg) >> FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
         rr = r0 + k / 2;
         cc = c0 + k % 2;
         if (in_image(rr, cc) && !planned_pixels.exists(int'(rr) * MAX_COLS + int'(cc)))
            add_write(32'(rr), 32'(cc), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      w.op = OP_REQUEST;
      w.row = row[COORD_W-1:0];
      w.col = col[COORD_W-1:0];
      w.blue = 8'($urandom);
      w.green = 8'($urandom);
      w.red = 8'($urandom);
      pending_words.push_back(w);
   endtask

   task automatic random_words(int n);
      int unsigned lim_r, lim_c;
      lim_r = (scale_cfg == 0) ? 4095 : ((eff_rows() + 1) << FRAC_BITS) / scale_cfg;
      lim_c = (scale_cfg == 0) ? 4095 : ((eff_cols() + 1) << FRAC_BITS) / scale_cfg;
      if (lim_r > 4095) lim_r = 4095;
      if (lim_c > 4095) lim_c = 4095;
      repeat (n) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 4) != 0)
               add_request($urandom_range(0, lim_r), $urandom_range(0, lim_c));
            else
               add_request($urandom_range(0, 4095), $urandom_range(0, 4095));
         end else if ($urandom_range(0, 4) != 0 && eff_rows() > 0 && eff_cols() > 0) begin
            add_write($urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1),
                      8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            add_write($urandom_range(0, 4095), $urandom_range(0, 4095),
                      8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ROWS:  rows_cfg = 32'(data[DIM_W-1:0]);
         CSR_COLS:  cols_cfg = 32'(data[DIM_W-1:0]);
         CSR_SCALE: scale_cfg = 32'(data[SCALE_W-1:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned scale, int n);
      wait_drained();
      write_csr(CSR_ROWS, CSR_W'(rows));
      write_csr(CSR_COLS, CSR_W'(cols));
      write_csr(CSR_SCALE, CSR_W'(scale));
      random_words(n);
   endtask

   // Sender: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      pixel_word_type w;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            if (req_op == OP_WRITE) begin
               if (in_image(64'(req_row), 64'(req_col)))
                  image_store[req_row * MAX_COLS + req_col] = {req_red_in, req_green_in,
                                                               req_blue_in};
            end else begin
               expected_pixels.push_back(blend_pixel(32'(req_row), 32'(req_col)));
            end
         end
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            next_valid = 1'b1;
            req_op <= w.op;
            req_row <= w.row;
            req_col <= w.col;
            req_blue_in <= w.blue;
            req_green_in <= w.green;
            req_red_in <= w.red;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: stall pattern steps through four modes in turn
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: b=%0d g=%0d r=%0d",
                        rsp_blue_out, rsp_green_out, rsp_red_out);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_blue_out !== want[7:0] || rsp_green_out !== want[15:8] ||
                rsp_red_out !== want[23:16]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                           want[7:0], want[15:8], want[23:16],
                           rsp_blue_out, rsp_green_out, rsp_red_out);
            end
         end
      end
      case (cycle_count[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= ($urandom_range(0, 9) != 0);
         default: rsp_ready <= (cycle_count[4:0] < 5'd20);
      endcase
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, 512 x 512 at step 1.0
      add_write(0, 0, 8'h00, 8'h00, 8'h00);
      add_write(0, 1, 8'hFF, 8'hFF, 8'hFF);
      add_write(1, 0, 8'hA5, 8'h5A, 8'hFF);
      add_write(1, 1, 8'hFF, 8'hFF, 8'hFF);
      add_write(4095, 4095, 8'h12, 8'h34, 8'h56);  // outside, dropped
      add_write(511, 511, 8'hFF, 8'h00, 8'h80);
      add_request(0, 0);
      add_request(0, 1);
      add_request(511, 511);   // right and lower neighbors outside
      add_request(4095, 4095);
      add_request(4095, 0);
      add_request(0, 4095);
      wait_drained();
      // Half-pixel step
      write_csr(CSR_SCALE, 12'd128);
      add_request(1, 1);
      add_request(0, 1);
      add_request(1, 0);
      // Largest step and a write to the unused index
      wait_drained();
      write_csr(CSR_UNUSED, 12'hFFF);
      write_csr(CSR_SCALE, 12'd4095);
      add_request(0, 0);
      add_request(1, 1);
      add_request(4095, 4095);
      random_words(20);

      run_phase(4, 5, 128, 40);
      run_phase(1, 1, 4095, 25);
      run_phase(0, 7, 200, 20);      // no rows: everything outside
      run_phase(9, 0, 77, 20);
      run_phase(16, 16, 0, 30);      // all requests sample the origin
      run_phase(1023, 1023, 1, 35);  // sizes clip to the store
      run_phase(512, 512, 4095, 35);
      run_phase(3, 512, 300, 40);
      run_phase(12, 10, 173, 60);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
